// ===== design/cawn_pkg.sv =====
// shared constants, register codes and pipeline control type of the contact angle normal block
package cawn_pkg;
  localparam int FIELD_W = 16;
  localparam int INV_W = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int PADDR_W = 5;
  localparam int APB_W = 32;
  localparam int SQ_W = 62;
  localparam int ROOT_W = 31;
  localparam int TS_W = 30;
  localparam logic [INV_W-1:0] INV_RESET = 32'h0001_0000;

  typedef enum logic [2:0] {
    REG_INV_X = 3'd0,
    REG_INV_Y = 3'd1,
    REG_INV_Z = 3'd2,
    REG_COS   = 3'd3,
    REG_SIN   = 3'd4
  } cawn_reg_e;

  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;
endpackage

// ===== design/cawn_in_if.sv =====
// input request channel: cube samples and wall normal
interface cawn_in_if;
  import cawn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [FIELD_W-1:0] phi_here;
  logic        [FIELD_W-1:0] phi_w;
  logic        [FIELD_W-1:0] phi_s;
  logic        [FIELD_W-1:0] phi_b;
  logic        [FIELD_W-1:0] phi_ws;
  logic        [FIELD_W-1:0] phi_wb;
  logic        [FIELD_W-1:0] phi_sb;
  logic        [FIELD_W-1:0] phi_wsb;
  logic signed [FIELD_W-1:0] wall_nx;
  logic signed [FIELD_W-1:0] wall_ny;
  logic signed [FIELD_W-1:0] wall_nz;

  modport source (
    output valid, phi_here, phi_w, phi_s, phi_b, phi_ws, phi_wb, phi_sb, phi_wsb,
    output wall_nx, wall_ny, wall_nz,
    input  ready
  );
  modport sink (
    input  valid, phi_here, phi_w, phi_s, phi_b, phi_ws, phi_wb, phi_sb, phi_wsb,
    input  wall_nx, wall_ny, wall_nz,
    output ready
  );
endinterface

// ===== design/cawn_out_if.sv =====
// output request channel: corrected normal
interface cawn_out_if;
  import cawn_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] normal_x;
  logic signed [FIELD_W-1:0] normal_y;
  logic signed [FIELD_W-1:0] normal_z;

  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// ===== design/contact_angle_wall_normal.sv =====
// top level: contact-angle corrected interface normal at a wall vertex
// pipeline: 15 arithmetic stages, 16 square-root stages, NORMAL_FRAC_BITS + 2 divider stages,
// a product stage and the output register; throughput is one request per cycle unless stalled,
// and the whole pipeline holds while a result waits on a low ready
// reset clears all valid bits and loads the register defaults
module contact_angle_wall_normal #(
  parameter int NORMAL_FRAC_BITS = cawn_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  cawn_in_if.sink                      in_i,
  cawn_out_if.source                   out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cawn_pkg::PADDR_W-1:0] paddr,
  input  logic [cawn_pkg::APB_W-1:0]   pwdata,
  output logic [cawn_pkg::APB_W-1:0]   prdata,
  output logic                         pready
);
  import cawn_pkg::*;

  localparam int N = NORMAL_FRAC_BITS;
  localparam int SUM_W = FIELD_W + 3;
  localparam int G_W = SUM_W + INV_W + 1;
  localparam int GM_W = G_W - 1;
  localparam int GS_W = 32;
  localparam int P1_W = GS_W + FIELD_W;
  localparam int D_W = P1_W + 2;
  localparam int DH_W = D_W + 1;
  localparam int TMP_W = D_W - N;
  localparam int P2_W = TMP_W + FIELD_W;
  localparam int PH_W = P2_W + 1;
  localparam int T_W = P2_W;
  localparam int TM_W = T_W - 1;
  localparam int SH_W = 7;
  localparam int QS_W = N + 2;
  localparam int PC_W = 2 * FIELD_W;
  localparam int PS_W = QS_W + FIELD_W;
  localparam int PF_W = ((PC_W > PS_W) ? PC_W : PS_W) + 1;
  localparam int SIDE1_W = 3 * TS_W + 3 + 3 * FIELD_W;
  localparam int SIDE2_W = 3 + 3 * FIELD_W;
  localparam int LIM = 1 << N;
  localparam int SAT_P = (LIM > 32767) ? 32767 : LIM;
  localparam int SAT_N = (LIM > 32768) ? -32768 : -LIM;

  // configuration registers
  logic        [INV_W-1:0]   inv_q [3];
  logic signed [FIELD_W-1:0] cos_q;
  logic signed [FIELD_W-1:0] sin_q;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) inv_q[i] <= INV_RESET;
      cos_q <= '0;
      sin_q <= FIELD_W'(32'd1 << N);
    end else if (wr_en) begin
      case (paddr[PADDR_W-1:2])
        REG_INV_X: inv_q[0] <= pwdata;
        REG_INV_Y: inv_q[1] <= pwdata;
        REG_INV_Z: inv_q[2] <= pwdata;
        REG_COS:   cos_q <= pwdata[FIELD_W-1:0];
        REG_SIN:   sin_q <= pwdata[FIELD_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[PADDR_W-1:2])
      REG_INV_X: prdata = inv_q[0];
      REG_INV_Y: prdata = inv_q[1];
      REG_INV_Z: prdata = inv_q[2];
      REG_COS:   prdata = APB_W'(cos_q);
      REG_SIN:   prdata = APB_W'(sin_q);
      default:   prdata = '0;
    endcase
  end

  // pipeline control
  logic adv;
  logic vout_q;
  assign adv        = !vout_q || out_o.ready;
  assign in_i.ready = adv;

  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q, v8_q;
  logic v9_q, v10_q, v11_q, v12_q, v13_q, v14_q, v15_q, vf1_q;
  logic sq_v, dv_v;

  logic signed [SUM_W-1:0]   sum1_q [3];
  logic signed [G_W-1:0]     g2_q   [3];
  logic        [GM_W-1:0]    gm3_q  [3];
  logic                      gn3_q  [3];
  logic        [GM_W-1:0]    or3_q;
  logic        [GM_W-1:0]    gm4_q  [3];
  logic                      gn4_q  [3];
  logic        [SH_W-1:0]    sh4_q;
  logic signed [GS_W-1:0]    gs5_q  [3];
  logic signed [GS_W-1:0]    gs6_q  [3];
  logic signed [P1_W-1:0]    p6_q   [3];
  logic signed [GS_W-1:0]    gs7_q  [3];
  logic signed [D_W-1:0]     d7_q;
  logic signed [GS_W-1:0]    gs8_q  [3];
  logic signed [TMP_W-1:0]   tmp8_q;
  logic signed [GS_W-1:0]    gs9_q  [3];
  logic signed [P2_W-1:0]    p9_q   [3];
  logic signed [T_W-1:0]     t10_q  [3];
  logic        [TM_W-1:0]    tm11_q [3];
  logic                      tn11_q [3];
  logic        [TM_W-1:0]    or11_q;
  logic        [TM_W-1:0]    tm12_q [3];
  logic                      tn12_q [3];
  logic        [SH_W-1:0]    sh12_q;
  logic        [TS_W-1:0]    tsm13_q [3];
  logic                      tn13_q  [3];
  logic        [TS_W-1:0]    tsm14_q [3];
  logic                      tn14_q  [3];
  logic        [2*TS_W-1:0]  sqr14_q [3];
  logic        [TS_W-1:0]    tsm15_q [3];
  logic                      tn15_q  [3];
  logic        [SQ_W-1:0]    sq15_q;
  logic signed [FIELD_W-1:0] n1_q [3], n2_q [3], n3_q [3], n4_q [3], n5_q [3];
  logic signed [FIELD_W-1:0] n6_q [3], n7_q [3], n8_q [3], n9_q [3], n10_q [3];
  logic signed [FIELD_W-1:0] n11_q [3], n12_q [3], n13_q [3], n14_q [3], n15_q [3];
  logic signed [PC_W-1:0]    pc_q [3];
  logic signed [PS_W-1:0]    ps_q [3];
  logic signed [FIELD_W-1:0] out_q [3];

  logic        [SQ_W-1:0]    sum_sq;
  logic signed [SUM_W-1:0]   sum_d [3];
  logic        [GM_W-1:0]    gm_d  [3];
  logic        [SH_W-1:0]    sh4_d;
  logic        [SH_W-1:0]    sh12_d;
  logic signed [GS_W-1:0]    gs_d  [3];
  logic signed [TMP_W-1:0]   tmp_d;
  logic signed [T_W-1:0]     t_d   [3];
  logic        [TM_W-1:0]    tm_d  [3];
  logic        [TS_W-1:0]    tsm_d [3];
  logic signed [FIELD_W-1:0] out_d [3];

  logic [ROOT_W-1:0]  sq_root;
  logic [SIDE1_W-1:0] sq_side_in, sq_side_out;
  logic [TS_W-1:0]    dm_in [3];
  logic [SIDE2_W-1:0] dv_side_in, dv_side_out;
  logic [N:0]         dq [3];
  logic signed [FIELD_W-1:0] dn [3];
  logic                      dtn [3];

  always_comb begin
    logic [SUM_W-1:0] p [8];
    p[0] = SUM_W'(in_i.phi_here);
    p[1] = SUM_W'(in_i.phi_w);
    p[2] = SUM_W'(in_i.phi_s);
    p[3] = SUM_W'(in_i.phi_b);
    p[4] = SUM_W'(in_i.phi_ws);
    p[5] = SUM_W'(in_i.phi_wb);
    p[6] = SUM_W'(in_i.phi_sb);
    p[7] = SUM_W'(in_i.phi_wsb);
    sum_d[0] = $signed((p[0] - p[1]) + (p[2] - p[4]) + (p[3] - p[5]) + (p[6] - p[7]));
    sum_d[1] = $signed((p[0] - p[2]) + (p[1] - p[4]) + (p[3] - p[6]) + (p[5] - p[7]));
    sum_d[2] = $signed((p[0] - p[3]) + (p[2] - p[6]) + (p[1] - p[5]) + (p[4] - p[7]));
  end

  // gradient magnitudes and first block scale
  always_comb begin
    logic [G_W-1:0]  a;
    logic [SH_W-1:0] bl;
    logic [GM_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      a = g2_q[i][G_W-1] ? -g2_q[i] : g2_q[i];
      gm_d[i] = a[GM_W-1:0];
    end
    bl = '0;
    for (int b = 0; b < GM_W; b++) if (or3_q[b]) bl = SH_W'(b + 1);
    sh4_d = (bl > SH_W'(31)) ? bl - SH_W'(31) : '0;
    for (int i = 0; i < 3; i++) begin
      m = gm4_q[i] >> sh4_q;
      gs_d[i] = gn4_q[i] ? -$signed({1'b0, m[GS_W-2:0]}) : $signed({1'b0, m[GS_W-2:0]});
    end
  end

  // projection onto the wall normal and tangent
  always_comb begin
    logic [D_W-1:0]  dm;
    logic [DH_W-1:0] dr;
    logic [P2_W-1:0] pm;
    logic [PH_W-1:0] pr;
    logic signed [T_W-1:0] rr;
    dm = d7_q[D_W-1] ? -d7_q : d7_q;
    dr = (DH_W'(dm) + (DH_W'(1) << (N - 1))) >> N;
    tmp_d = d7_q[D_W-1] ? -$signed({1'b0, dr[TMP_W-2:0]}) : $signed({1'b0, dr[TMP_W-2:0]});
    for (int i = 0; i < 3; i++) begin
      pm = p9_q[i][P2_W-1] ? -p9_q[i] : p9_q[i];
      pr = (PH_W'(pm) + (PH_W'(1) << (N - 1))) >> N;
      rr = $signed(pr[T_W-1:0]);
      if (p9_q[i][P2_W-1]) rr = -rr;
      t_d[i] = T_W'(gs9_q[i]) - rr;
    end
  end

  // second block scale
  always_comb begin
    logic [T_W-1:0]  a;
    logic [SH_W-1:0] bl;
    logic [TM_W-1:0] m;
    for (int i = 0; i < 3; i++) begin
      a = t10_q[i][T_W-1] ? -t10_q[i] : t10_q[i];
      tm_d[i] = a[TM_W-1:0];
    end
    bl = '0;
    for (int b = 0; b < TM_W; b++) if (or11_q[b]) bl = SH_W'(b + 1);
    sh12_d = (bl > SH_W'(TS_W)) ? bl - SH_W'(TS_W) : '0;
    for (int i = 0; i < 3; i++) begin
      m = tm12_q[i] >> sh12_q;
      tsm_d[i] = m[TS_W-1:0];
    end
  end

  assign sum_sq = SQ_W'(sqr14_q[0]) + SQ_W'(sqr14_q[1]) + SQ_W'(sqr14_q[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0;
      v5_q <= 1'b0; v6_q <= 1'b0; v7_q <= 1'b0; v8_q <= 1'b0;
      v9_q <= 1'b0; v10_q <= 1'b0; v11_q <= 1'b0; v12_q <= 1'b0;
      v13_q <= 1'b0; v14_q <= 1'b0; v15_q <= 1'b0; vf1_q <= 1'b0;
      vout_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_i.valid; v2_q <= v1_q; v3_q <= v2_q; v4_q <= v3_q;
      v5_q <= v4_q; v6_q <= v5_q; v7_q <= v6_q; v8_q <= v7_q;
      v9_q <= v8_q; v10_q <= v9_q; v11_q <= v10_q; v12_q <= v11_q;
      v13_q <= v12_q; v14_q <= v13_q; v15_q <= v14_q;
      vf1_q <= dv_v; vout_q <= vf1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      n1_q[0] <= in_i.wall_nx;
      n1_q[1] <= in_i.wall_ny;
      n1_q[2] <= in_i.wall_nz;
      or3_q  <= gm_d[0] | gm_d[1] | gm_d[2];
      sh4_q  <= sh4_d;
      d7_q   <= D_W'(p6_q[0]) + D_W'(p6_q[1]) + D_W'(p6_q[2]);
      tmp8_q <= tmp_d;
      or11_q <= tm_d[0] | tm_d[1] | tm_d[2];
      sh12_q <= sh12_d;
      sq15_q <= sum_sq;
      for (int i = 0; i < 3; i++) begin
        sum1_q[i] <= sum_d[i];
        g2_q[i]   <= sum1_q[i] * $signed({1'b0, inv_q[i]});
        gm3_q[i]  <= gm_d[i];
        gn3_q[i]  <= g2_q[i][G_W-1];
        gm4_q[i]  <= gm3_q[i];
        gn4_q[i]  <= gn3_q[i];
        gs5_q[i]  <= gs_d[i];
        p6_q[i]   <= gs5_q[i] * n5_q[i];
        gs6_q[i]  <= gs5_q[i];
        gs7_q[i]  <= gs6_q[i];
        gs8_q[i]  <= gs7_q[i];
        gs9_q[i]  <= gs8_q[i];
        p9_q[i]   <= tmp8_q * n8_q[i];
        t10_q[i]  <= t_d[i];
        tm11_q[i] <= tm_d[i];
        tn11_q[i] <= t10_q[i][T_W-1];
        tm12_q[i] <= tm11_q[i];
        tn12_q[i] <= tn11_q[i];
        tsm13_q[i] <= tsm_d[i];
        tn13_q[i]  <= tn12_q[i];
        tsm14_q[i] <= tsm13_q[i];
        tn14_q[i]  <= tn13_q[i];
        sqr14_q[i] <= tsm13_q[i] * tsm13_q[i];
        tsm15_q[i] <= tsm14_q[i];
        tn15_q[i]  <= tn14_q[i];
        n2_q[i] <= n1_q[i]; n3_q[i] <= n2_q[i]; n4_q[i] <= n3_q[i];
        n5_q[i] <= n4_q[i]; n6_q[i] <= n5_q[i]; n7_q[i] <= n6_q[i];
        n8_q[i] <= n7_q[i]; n9_q[i] <= n8_q[i]; n10_q[i] <= n9_q[i];
        n11_q[i] <= n10_q[i]; n12_q[i] <= n11_q[i]; n13_q[i] <= n12_q[i];
        n14_q[i] <= n13_q[i]; n15_q[i] <= n14_q[i];
        pc_q[i]  <= dn[i] * cos_q;
        ps_q[i]  <= (dtn[i] ? -$signed(QS_W'(dq[i])) : $signed(QS_W'(dq[i]))) * sin_q;
        out_q[i] <= out_d[i];
      end
    end
  end

  assign sq_side_in = {tsm15_q[0], tsm15_q[1], tsm15_q[2], tn15_q[0], tn15_q[1], tn15_q[2],
                       n15_q[0], n15_q[1], n15_q[2]};

  cawn_sqrt #(
    .SIDE_W (SIDE1_W)
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: adv, valid: v15_q}),
    .sq_i    (sq15_q),
    .side_i  (sq_side_in),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side_out)
  );

  assign {dm_in[0], dm_in[1], dm_in[2], dv_side_in} = sq_side_out;

  cawn_div #(
    .NFB    (N),
    .SIDE_W (SIDE2_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   ('{en: adv, valid: sq_v}),
    .m_i     (dm_in),
    .root_i  (sq_root),
    .side_i  (dv_side_in),
    .valid_o (dv_v),
    .q_o     (dq),
    .side_o  (dv_side_out)
  );

  assign {dtn[0], dtn[1], dtn[2], dn[0], dn[1], dn[2]} = dv_side_out;

  // final rounding and saturation
  always_comb begin
    logic signed [PF_W-1:0] v;
    logic        [PF_W-1:0] vm;
    logic        [PF_W-1:0] r;
    logic signed [PF_W-1:0] o;
    for (int i = 0; i < 3; i++) begin
      v  = PF_W'(pc_q[i]) + PF_W'(ps_q[i]);
      vm = v[PF_W-1] ? -v : v;
      r  = (vm + (PF_W'(1) << (N - 1))) >> N;
      o  = v[PF_W-1] ? -$signed(r) : $signed(r);
      if (o > PF_W'(SAT_P)) o = PF_W'(SAT_P);
      if (o < PF_W'(SAT_N)) o = PF_W'(SAT_N);
      out_d[i] = o[FIELD_W-1:0];
    end
  end

  assign out_o.valid    = vout_q;
  assign out_o.normal_x = out_q[0];
  assign out_o.normal_y = out_q[1];
  assign out_o.normal_z = out_q[2];

  a_in_to_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> v1_q)
    else $error("accepted request did not enter the pipeline");

  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable({v1_q, v5_q, v10_q, v15_q, sq_v, dv_v, vf1_q, vout_q}))
    else $error("pipeline moved during a stall");

  a_quot_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v |-> ((dq[0] <= (N+1)'(LIM)) && (dq[1] <= (N+1)'(LIM)) && (dq[2] <= (N+1)'(LIM))))
    else $error("normalized tangent exceeds one");

  a_out_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vout_q |-> (($signed(out_q[0]) <= SAT_P) && ($signed(out_q[0]) >= SAT_N) &&
                ($signed(out_q[1]) <= SAT_P) && ($signed(out_q[1]) >= SAT_N) &&
                ($signed(out_q[2]) <= SAT_P) && ($signed(out_q[2]) >= SAT_N)))
    else $error("result outside saturation range");
endmodule

// ===== design/cawn_sqrt.sv =====
// pipelined integer square root, two root bits per stage (one in the last stage), with sideband data
module cawn_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cawn_pkg::pipe_ctl_t         ctl_i,
  input  logic [cawn_pkg::SQ_W-1:0]   sq_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [cawn_pkg::ROOT_W-1:0] root_o,
  output logic [SIDE_W-1:0]           side_o
);
  import cawn_pkg::*;

  localparam int SPS = 2;
  localparam int ST = (ROOT_W + SPS - 1) / SPS;
  localparam int SR_W = ROOT_W + 3;

  logic              v_q    [ST];
  logic [SR_W-1:0]   rem_q  [ST];
  logic [SR_W-1:0]   rem_d  [ST];
  logic [ROOT_W-1:0] root_q [ST];
  logic [ROOT_W-1:0] root_d [ST];
  logic [SQ_W-1:0]   x_q    [ST];
  logic [SQ_W-1:0]   x_d    [ST];
  logic [SIDE_W-1:0] side_q [ST];

  always_comb begin
    logic [SR_W-1:0]   r;
    logic [ROOT_W-1:0] rt;
    logic [SQ_W-1:0]   x;
    logic [SR_W-1:0]   trial;
    for (int k = 0; k < ST; k++) begin
      if (k == 0) begin
        r  = '0;
        rt = '0;
        x  = sq_i;
      end else begin
        r  = rem_q[k-1];
        rt = root_q[k-1];
        x  = x_q[k-1];
      end
      for (int j = 0; j < SPS; j++) begin
        if (k * SPS + j < ROOT_W) begin
          r     = {r[SR_W-3:0], x[SQ_W-1 -: 2]};
          x     = {x[SQ_W-3:0], 2'b00};
          trial = {{(SR_W-ROOT_W-2){1'b0}}, rt, 2'b01};
          if (r >= trial) begin
            r  = r - trial;
            rt = {rt[ROOT_W-2:0], 1'b1};
          end else begin
            rt = {rt[ROOT_W-2:0], 1'b0};
          end
        end
      end
      rem_d[k]  = r;
      root_d[k] = rt;
      x_d[k]    = x;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ST; k++) v_q[k] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
      for (int k = 1; k < ST; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      side_q[0] <= side_i;
      for (int k = 0; k < ST; k++) begin
        rem_q[k]  <= rem_d[k];
        root_q[k] <= root_d[k];
        x_q[k]    <= x_d[k];
      end
      for (int k = 1; k < ST; k++) side_q[k] <= side_q[k-1];
    end
  end

  assign valid_o = v_q[ST-1];
  assign root_o  = root_q[ST-1];
  assign side_o  = side_q[ST-1];
endmodule

// ===== design/cawn_div.sv =====
// three-lane pipelined restoring divider, one quotient bit per stage after the first, with sideband data
module cawn_div #(
  parameter int NFB    = cawn_pkg::NORMAL_FRAC_BITS_DEF,
  parameter int SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cawn_pkg::pipe_ctl_t         ctl_i,
  input  logic [cawn_pkg::TS_W-1:0]   m_i [3],
  input  logic [cawn_pkg::ROOT_W-1:0] root_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic [NFB:0]                q_o [3],
  output logic [SIDE_W-1:0]           side_o
);
  import cawn_pkg::*;

  localparam int QB = NFB + 1;
  localparam int NUM_W = TS_W + NFB + 1;
  localparam int DV_W = ROOT_W + 1;
  localparam int REM_W = DV_W + 1;

  logic              v_q    [QB+1];
  logic [DV_W-1:0]   dv_q   [QB+1];
  logic [SIDE_W-1:0] side_q [QB+1];
  logic [REM_W-1:0]  rem_q  [QB+1][3];
  logic [REM_W-1:0]  rem_d  [QB+1][3];
  logic [QB-1:0]     low_q  [QB+1][3];
  logic [QB-1:0]     low_d  [QB+1][3];
  logic [QB-1:0]     q_q    [QB+1][3];
  logic [QB-1:0]     q_d    [QB+1][3];
  logic [DV_W-1:0]   magn;

  assign magn = {1'b0, root_i} + DV_W'(1);

  always_comb begin
    logic [NUM_W-1:0] num;
    logic [REM_W-1:0] r;
    logic             b;
    for (int l = 0; l < 3; l++) begin
      num = (NUM_W'(m_i[l]) << NFB) + NUM_W'(magn >> 1);
      rem_d[0][l] = REM_W'(num >> QB);
      low_d[0][l] = num[QB-1:0];
      q_d[0][l]   = '0;
    end
    for (int k = 1; k <= QB; k++) begin
      for (int l = 0; l < 3; l++) begin
        r = {rem_q[k-1][l][REM_W-2:0], low_q[k-1][l][QB-1]};
        b = (r >= {1'b0, dv_q[k-1]});
        if (b) r = r - {1'b0, dv_q[k-1]};
        rem_d[k][l] = r;
        low_d[k][l] = {low_q[k-1][l][QB-2:0], 1'b0};
        q_d[k][l]   = {q_q[k-1][l][QB-2:0], b};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QB; k++) v_q[k] <= 1'b0;
    end else if (ctl_i.en) begin
      v_q[0] <= ctl_i.valid;
      for (int k = 1; k <= QB; k++) v_q[k] <= v_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      dv_q[0]   <= magn;
      side_q[0] <= side_i;
      for (int k = 1; k <= QB; k++) begin
        dv_q[k]   <= dv_q[k-1];
        side_q[k] <= side_q[k-1];
      end
      for (int k = 0; k <= QB; k++) begin
        for (int l = 0; l < 3; l++) begin
          rem_q[k][l] <= rem_d[k][l];
          low_q[k][l] <= low_d[k][l];
          q_q[k][l]   <= q_d[k][l];
        end
      end
    end
  end

  assign valid_o = v_q[QB];
  assign side_o  = side_q[QB];
  always_comb begin
    for (int l = 0; l < 3; l++) q_o[l] = q_q[QB][l];
  end
endmodule

// ===== verif/tb_contact_angle_wall_normal.sv =====
// testbench for the contact angle wall normal block: random and directed requests checked against a predictor
module tb_contact_angle_wall_normal;
  timeunit 1ns;
  timeprecision 1ps;
  import cawn_pkg::*;

  typedef struct {
    logic [15:0] phi [8];
    logic signed [15:0] wn [3];
  } vertex_t;

  typedef struct {
    logic signed [15:0] nrm [3];
  } normal_t;

  localparam int NFB = 14;
  localparam int LATENCY = 49;
  localparam int WATCHDOG = 20000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [APB_W-1:0] pwdata = '0;
  logic [APB_W-1:0] prdata;
  logic pready;
  int errors = 0;
  int idle_pct = 7;
  longint stall_cycles = 0;

  cawn_in_if in_ch();
  cawn_out_if out_ch();

  contact_angle_wall_normal dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(in_ch.sink), .out_o(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk_i = ~clk_i;

  class normal_scoreboard;
    longint unsigned inv [3];
    longint cos_c;
    longint sin_c;
    normal_t pending [$];

    function new();
      inv = '{65536, 65536, 65536};
      cos_c = 0;
      sin_c = 16384;
    endfunction

    function void set_reg(cawn_reg_e r, logic [31:0] v);
      case (r)
        REG_INV_X: inv[0] = v;
        REG_INV_Y: inv[1] = v;
        REG_INV_Z: inv[2] = v;
        REG_COS: cos_c = longint'($signed(v[15:0]));
        REG_SIN: sin_c = longint'($signed(v[15:0]));
        default: ;
      endcase
    endfunction

    function longint round_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = (m + (64'sd1 << (s - 1))) >>> s;
      return v < 0 ? -m : m;
    endfunction

    function longint trunc_shift(longint v, int s);
      longint m;
      m = v < 0 ? -v : v;
      m = m >>> s;
      return v < 0 ? -m : m;
    endfunction

    function int scale_of(longint a, longint b, longint c, int bits);
      longint unsigned m;
      int s;
      m = a < 0 ? -a : a;
      if ((b < 0 ? -b : b) > m) m = b < 0 ? -b : b;
      if ((c < 0 ? -c : c) > m) m = c < 0 ? -c : c;
      s = 0;
      while (s < 63 && (m >> s) >= (64'd1 << bits)) s++;
      return s;
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b >>= 2;
      while (b != 0) begin
        if (x >= r + b) begin
          x -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_vertex(vertex_t v);
      longint p [8];
      longint g [3], n [3], t [3], ts [3], sm [3];
      longint d, tmp, q, o;
      longint unsigned sq, magn, m;
      int s;
      normal_t r;
      for (int i = 0; i < 8; i++) p[i] = longint'(v.phi[i]);
      for (int i = 0; i < 3; i++) n[i] = longint'(v.wn[i]);
      sm[0] = (p[0] - p[1]) + (p[2] - p[4]) + (p[3] - p[5]) + (p[6] - p[7]);
      sm[1] = (p[0] - p[2]) + (p[1] - p[4]) + (p[3] - p[6]) + (p[5] - p[7]);
      sm[2] = (p[0] - p[3]) + (p[2] - p[6]) + (p[1] - p[5]) + (p[4] - p[7]);
      for (int i = 0; i < 3; i++) g[i] = sm[i] * longint'(inv[i]);
      s = scale_of(g[0], g[1], g[2], 31);
      for (int i = 0; i < 3; i++) g[i] = trunc_shift(g[i], s);
      d = g[0] * n[0] + g[1] * n[1] + g[2] * n[2];
      tmp = round_shift(d, NFB);
      for (int i = 0; i < 3; i++) t[i] = g[i] - round_shift(tmp * n[i], NFB);
      s = scale_of(t[0], t[1], t[2], 30);
      sq = 0;
      for (int i = 0; i < 3; i++) begin
        ts[i] = trunc_shift(t[i], s);
        sq += longint'(ts[i] * ts[i]);
      end
      magn = int_sqrt(sq) + 1;
      for (int i = 0; i < 3; i++) begin
        m = ts[i] < 0 ? -ts[i] : ts[i];
        m = ((m << NFB) + (magn >> 1)) / magn;
        q = ts[i] < 0 ? -longint'(m) : longint'(m);
        o = round_shift(n[i] * cos_c + q * sin_c, NFB);
        if (o > 16384) o = 16384;
        if (o < -16384) o = -16384;
        r.nrm[i] = o[15:0];
      end
      pending.push_back(r);
    endfunction

    function void check_normal(normal_t a);
      normal_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result %0d %0d %0d", $time, a.nrm[0], a.nrm[1], a.nrm[2]);
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 3; i++)
        if (a.nrm[i] !== e.nrm[i]) begin
          errors++;
          $display("%0t normal[%0d] expected %0d actual %0d", $time, i, e.nrm[i], a.nrm[i]);
        end
    endfunction
  endclass

  normal_scoreboard sb = new();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.phi_here = '0; in_ch.phi_w = '0; in_ch.phi_s = '0; in_ch.phi_b = '0;
    in_ch.phi_ws = '0; in_ch.phi_wb = '0; in_ch.phi_sb = '0; in_ch.phi_wsb = '0;
    in_ch.wall_nx = '0; in_ch.wall_ny = '0; in_ch.wall_nz = '0;
    out_ch.ready = 1'b0;
  end

  // result side
  always @(posedge clk_i) begin
    normal_t a;
    if (rst_ni) begin
      if (out_ch.valid && out_ch.ready) begin
        a.nrm[0] = out_ch.normal_x;
        a.nrm[1] = out_ch.normal_y;
        a.nrm[2] = out_ch.normal_z;
        sb.check_normal(a);
      end
      out_ch.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles > WATCHDOG) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic write_reg(cawn_reg_e r, logic [31:0] v);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= PADDR_W'(4 * int'(r)); pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    sb.set_reg(r, v);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_vertex(vertex_t v);
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.phi_here <= v.phi[0]; in_ch.phi_w <= v.phi[1];
    in_ch.phi_s <= v.phi[2]; in_ch.phi_b <= v.phi[3];
    in_ch.phi_ws <= v.phi[4]; in_ch.phi_wb <= v.phi[5];
    in_ch.phi_sb <= v.phi[6]; in_ch.phi_wsb <= v.phi[7];
    in_ch.wall_nx <= v.wn[0]; in_ch.wall_ny <= v.wn[1]; in_ch.wall_nz <= v.wn[2];
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    sb.note_vertex(v);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  function automatic vertex_t random_vertex(int mode);
    vertex_t v;
    logic signed [15:0] unit [6] = '{16384, -16384, 11585, -11585, 9459, -9459};
    for (int i = 0; i < 8; i++)
      case (mode)
        0: v.phi[i] = 16'($urandom_range(32768));
        1: v.phi[i] = $urandom_range(1) ? 16'd32768 : 16'd0;
        default: v.phi[i] = 16'($urandom);
      endcase
    for (int i = 0; i < 3; i++)
      case (mode)
        0: v.wn[i] = $urandom_range(1) ? unit[$urandom_range(5)] : 16'sd0;
        1: v.wn[i] = $signed(16'($urandom_range(32768))) - 16'sd16384;
        default: v.wn[i] = 16'($urandom);
      endcase
    return v;
  endfunction

  function automatic vertex_t make_vertex(logic [15:0] a, logic [15:0] b,
                                          logic signed [15:0] x, logic signed [15:0] y,
                                          logic signed [15:0] z);
    vertex_t v;
    for (int i = 0; i < 8; i++) v.phi[i] = (i == 0 || i == 3) ? a : b;
    v.wn = '{x, y, z};
    return v;
  endfunction

  initial begin
    logic [31:0] inv_set [5] = '{32'h0001_0000, 32'hFFFF_FFFF, 32'h0, 32'h0004_8000, 32'h0000_0001};
    logic [15:0] ang_set [5] = '{16'h0, 16'h4000, 16'hC000, 16'h7FFF, 16'h8000};
    vertex_t v;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed
    send_vertex(make_vertex(16'd0, 16'd0, 16'sd0, 16'sd0, 16'sd16384));
    send_vertex(make_vertex(16'd32768, 16'd0, 16'sd0, 16'sd0, 16'sd16384));
    send_vertex(make_vertex(16'd0, 16'd32768, 16'sd16384, 16'sd0, 16'sd0));
    send_vertex(make_vertex(16'd32768, 16'd32768, -16'sd16384, 16'sd0, 16'sd0));
    send_vertex(make_vertex(16'hFFFF, 16'h0, 16'sd0, -16'sd16384, 16'sd0));
    send_vertex(make_vertex(16'h0, 16'hFFFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF));
    send_vertex(make_vertex(16'h8000, 16'h0, 16'sd11585, 16'sd11585, 16'sd0));
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_INV_X, ph < 5 ? inv_set[ph] : $urandom);
      write_reg(REG_INV_Y, ph < 5 ? inv_set[(ph + 1) % 5] : $urandom);
      write_reg(REG_INV_Z, ph < 5 ? inv_set[(ph + 2) % 5] : $urandom);
      write_reg(REG_COS, ph < 5 ? ang_set[ph] : $urandom);
      write_reg(REG_SIN, ph < 5 ? ang_set[(ph + 3) % 5] : $urandom);
      idle_pct = (ph == 3) ? 0 : 7;
      for (int k = 0; k < 130; k++) begin
        v = random_vertex($urandom_range(9) < 8 ? $urandom_range(1) : 2);
        send_vertex(v);
      end
      drain();
    end
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
